[rtl/i2cbs_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
// Depends on nothing; imported by the sequencer top level.
`default_nettype none

package i2cbs_pkg;

    localparam int STEP_W  = 5;
    localparam int PHASE_W = 2;

    // Command codes carried in the kind field; the idle code also marks no command.
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_SACK  = 3'd5,
        CMD_RACK  = 3'd6
    } cmd_t;

    // Phases of one data bit: set SDA or raise SCL, raise SCL or sample, drop SCL.
    localparam logic [PHASE_W-1:0] PH_FIRST = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MID   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LAST  = 2'd2;

    // Number of ticks each command sequence takes.
    function automatic logic [STEP_W-1:0] seq_len(input cmd_t cmd);
        logic [STEP_W-1:0] len;
        begin
            case (cmd)
                CMD_START: len = 5'd4;
                CMD_STOP:  len = 5'd3;
                CMD_WRITE: len = 5'd24;
                CMD_READ:  len = 5'd25;
                CMD_SACK:  len = 5'd3;
                CMD_RACK:  len = 5'd4;
                default:   len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/i2c_master_bit_sequencer.sv]
// I2C master bit sequencer: one request is one bus bit-time tick, one result per tick.
// Depends on i2cbs_pkg for the command enum and sequence lengths.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_ready  | kind, write_data, ack_to_send, sda_in
//   out     | out_valid/out_ready| scl_out, sda_out, busy_res, done_res,
//           |                    | read_data, ack_received
//
// The sequencer state and the result register are both written at the edge that accepts
// a request, so a request can enter every cycle unless a held result is stalled.
// The result shows on the cycle after acceptance and is held until taken.
// in_ready drops only while a result is held and out_ready is low.
// Reset (rst_n low) returns to idle with both lines released and the ack state high; results are not reset.
`default_nettype none

module i2c_master_bit_sequencer
    import i2cbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] kind,
    input  wire logic [7:0] write_data,
    input  wire logic       ack_to_send,
    input  wire logic       sda_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            scl_out,
    output logic            sda_out,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      read_data,
    output logic            ack_received
);

    cmd_t               cmd_reg, cmd_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         shift_reg, shift_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               rack_reg, rack_next;
    logic [7:0]         last_read_reg, last_read_next;

    logic               out_valid_reg;
    logic               scl_out_reg, sda_out_reg, busy_out_reg, done_out_reg;
    logic [7:0]         read_out_reg;
    logic               rack_out_reg;

    logic               in_fire;
    logic               cmd_begin;
    cmd_t               eff_cmd;
    logic [STEP_W-1:0]  eff_step;
    logic [PHASE_W-1:0] eff_phase;
    logic [7:0]         eff_shift;
    logic               last_step;
    logic               phase_hold;
    logic [PHASE_W-1:0] phase_adv;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // A command is taken only from idle; kind seven and tick-only do nothing.
    always_comb
    begin
        cmd_begin = (cmd_reg == CMD_IDLE) && (kind inside {[CMD_START:CMD_RACK]});
        eff_cmd   = cmd_begin ? cmd_t'(kind) : cmd_reg;
        eff_step  = cmd_begin ? '0 : step_reg;
        eff_phase = cmd_begin ? PH_FIRST : phase_reg;
        eff_shift = shift_reg;
        if (cmd_begin && (cmd_t'(kind) == CMD_WRITE))
        begin
            eff_shift = write_data;
        end
        else if (cmd_begin && (cmd_t'(kind) == CMD_READ))
        begin
            eff_shift = '0;
        end
        last_step = (eff_cmd != CMD_IDLE) &&
                    (eff_step == (seq_len(eff_cmd) - 5'd1));
    end

    // Next command and step counters.
    always_comb
    begin
        // read spends its first tick releasing SDA before the bit phases start
        phase_hold = (eff_cmd == CMD_READ) && (eff_step == '0);
        phase_adv  = (eff_phase == PH_LAST) ? PH_FIRST : eff_phase + 2'd1;
        if (last_step)
        begin
            cmd_next   = CMD_IDLE;
            step_next  = '0;
            phase_next = PH_FIRST;
        end
        else if (eff_cmd != CMD_IDLE)
        begin
            cmd_next   = eff_cmd;
            step_next  = eff_step + 5'd1;
            phase_next = phase_hold ? eff_phase : phase_adv;
        end
        else
        begin
            cmd_next   = CMD_IDLE;
            step_next  = step_reg;
            phase_next = phase_reg;
        end
    end

    // Pin action for this tick.
    always_comb
    begin
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        shift_next     = eff_shift;
        rack_next      = rack_reg;
        last_read_next = last_read_reg;
        case (eff_cmd)
            CMD_START:
            begin
                case (eff_step)
                    5'd0:    sda_next = 1'b1;
                    5'd1:    scl_next = 1'b1;
                    5'd2:    sda_next = 1'b0;
                    default: scl_next = 1'b0;
                endcase
            end
            CMD_STOP:
            begin
                case (eff_step)
                    5'd0:    sda_next = 1'b0;
                    5'd1:    scl_next = 1'b1;
                    default: sda_next = 1'b1;
                endcase
            end
            CMD_WRITE:
            begin
                case (eff_phase)
                    PH_FIRST: sda_next = eff_shift[7];
                    PH_MID:   scl_next = 1'b1;
                    default:
                    begin
                        scl_next   = 1'b0;
                        shift_next = {eff_shift[6:0], 1'b0};
                    end
                endcase
            end
            CMD_READ:
            begin
                if (phase_hold)
                begin
                    sda_next = 1'b1;
                end
                else
                begin
                    case (eff_phase)
                        PH_FIRST: scl_next   = 1'b1;
                        PH_MID:   shift_next = {eff_shift[6:0], sda_in};
                        default:  scl_next   = 1'b0;
                    endcase
                end
                if (last_step)
                begin
                    last_read_next = shift_next;
                end
            end
            CMD_SACK:
            begin
                case (eff_step)
                    5'd0:    sda_next = ack_to_send;
                    5'd1:    scl_next = 1'b1;
                    default: scl_next = 1'b0;
                endcase
            end
            CMD_RACK:
            begin
                case (eff_step)
                    5'd0:    sda_next  = 1'b1;
                    5'd1:    scl_next  = 1'b1;
                    5'd2:    rack_next = sda_in;
                    default: scl_next  = 1'b0;
                endcase
            end
            default:
            begin
                // idle tick: hold the lines
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_IDLE;
            step_reg      <= '0;
            phase_reg     <= PH_FIRST;
            shift_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rack_reg      <= 1'b1;
            last_read_reg <= '0;
        end
        else if (in_fire)
        begin
            cmd_reg       <= cmd_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            rack_reg      <= rack_next;
            last_read_reg <= last_read_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            scl_out_reg  <= scl_next;
            sda_out_reg  <= sda_next;
            busy_out_reg <= (cmd_next != CMD_IDLE);
            done_out_reg <= last_step;
            read_out_reg <= last_read_next;
            rack_out_reg <= rack_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_out      = scl_out_reg;
    assign sda_out      = sda_out_reg;
    assign busy_res     = busy_out_reg;
    assign done_res     = done_out_reg;
    assign read_data    = read_out_reg;
    assign ack_received = rack_out_reg;

    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg == CMD_IDLE) |-> (step_reg == '0 && phase_reg == PH_FIRST))
        else $error("step counters not cleared while idle");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("bit phase out of range");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_out_reg && busy_out_reg))
        else $error("result marks a sequence both done and busy");

    a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd_reg == CMD_IDLE && kind == CMD_IDLE) |=>
        (scl_reg == $past(scl_reg) && sda_reg == $past(sda_reg)))
        else $error("idle tick moved a bus line");

endmodule

`default_nettype wire

[tb/sv/i2cbs_tb_pkg.sv]
// Scoreboard for the I2C master bit sequencer bench: per-tick line predictor and checker.
// Depends on i2cbs_pkg for the command enum and bit phase constants.
package i2cbs_tb_pkg;

    import i2cbs_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
        logic       ack;
    } bus_result_t;

    class i2c_tick_scoreboard;

        cmd_t        cur_cmd;
        logic [4:0]  step;
        logic [7:0]  shift_reg;
        logic [7:0]  last_byte;
        logic        scl_lvl;
        logic        sda_lvl;
        logic        ack_lvl;
        bus_result_t expected_lines[$];
        int          mismatches;
        int          checked;
        int          finished_cmds;

        function new();
            cur_cmd       = CMD_IDLE;
            step          = '0;
            shift_reg     = '0;
            last_byte     = '0;
            scl_lvl       = 1'b1;
            sda_lvl       = 1'b1;
            ack_lvl       = 1'b1;
            mismatches    = 0;
            checked       = 0;
            finished_cmds = 0;
        endfunction

        function int tick_count(cmd_t c);
            case (c)
                CMD_START: return 4;
                CMD_STOP:  return 3;
                CMD_WRITE: return 24;
                CMD_READ:  return 25;
                CMD_SACK:  return 3;
                CMD_RACK:  return 4;
                default:   return 0;
            endcase
        endfunction

        function bit busy();
            return cur_cmd != CMD_IDLE;
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        // Advance the bus by one accepted tick request and queue the expected lines.
        function void note_tick(logic [2:0] k, logic [7:0] wd, logic ack_bit, logic sda_bit);
            int          bit_idx;
            int          t;
            logic [1:0]  ph;
            logic        done_now;
            bus_result_t line;
            done_now = 1'b0;
            if (cur_cmd == CMD_IDLE && k >= CMD_START && k <= CMD_RACK)
            begin
                cur_cmd = cmd_t'(k);
                step = '0;
                if (cur_cmd == CMD_WRITE)
                    shift_reg = wd;
                else if (cur_cmd == CMD_READ)
                    shift_reg = '0;
            end
            if (cur_cmd != CMD_IDLE)
            begin
                case (cur_cmd)
                    CMD_START:
                    begin
                        case (step)
                            5'd0:    sda_lvl = 1'b1;
                            5'd1:    scl_lvl = 1'b1;
                            5'd2:    sda_lvl = 1'b0;
                            default: scl_lvl = 1'b0;
                        endcase
                    end
                    CMD_STOP:
                    begin
                        case (step)
                            5'd0:    sda_lvl = 1'b0;
                            5'd1:    scl_lvl = 1'b1;
                            default: sda_lvl = 1'b1;
                        endcase
                    end
                    CMD_WRITE:
                    begin
                        bit_idx = int'(step) / 3;
                        ph = 2'(int'(step) % 3);
                        if (ph == PH_FIRST)
                            sda_lvl = shift_reg[7 - bit_idx];
                        else if (ph == PH_MID)
                            scl_lvl = 1'b1;
                        else
                            scl_lvl = 1'b0;
                    end
                    CMD_READ:
                    begin
                        if (step == 5'd0)
                            sda_lvl = 1'b1;
                        else
                        begin
                            t = int'(step) - 1;
                            bit_idx = t / 3;
                            ph = 2'(t % 3);
                            if (ph == PH_FIRST)
                                scl_lvl = 1'b1;
                            else if (ph == PH_MID)
                            begin
                                if (sda_bit)
                                    shift_reg[7 - bit_idx] = 1'b1;
                            end
                            else
                                scl_lvl = 1'b0;
                        end
                    end
                    CMD_SACK:
                    begin
                        case (step)
                            5'd0:    sda_lvl = ack_bit;
                            5'd1:    scl_lvl = 1'b1;
                            default: scl_lvl = 1'b0;
                        endcase
                    end
                    default:
                    begin
                        case (step)
                            5'd0:    sda_lvl = 1'b1;
                            5'd1:    scl_lvl = 1'b1;
                            5'd2:    ack_lvl = sda_bit;
                            default: scl_lvl = 1'b0;
                        endcase
                    end
                endcase
                step = step + 5'd1;
                if (int'(step) >= tick_count(cur_cmd))
                begin
                    if (cur_cmd == CMD_READ)
                        last_byte = shift_reg;
                    done_now = 1'b1;
                    cur_cmd = CMD_IDLE;
                    step = '0;
                    finished_cmds++;
                end
            end
            line.scl   = scl_lvl;
            line.sda   = sda_lvl;
            line.busy  = (cur_cmd != CMD_IDLE);
            line.done  = done_now;
            line.rdata = last_byte;
            line.ack   = ack_lvl;
            expected_lines.push_back(line);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                          checked, name, got, want));
        endtask

        task check_tick(bus_result_t got);
            bus_result_t want;
            if (expected_lines.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = expected_lines.pop_front();
            check_field("scl_out", 8'(got.scl), 8'(want.scl));
            check_field("sda_out", 8'(got.sda), 8'(want.sda));
            check_field("busy_res", 8'(got.busy), 8'(want.busy));
            check_field("done_res", 8'(got.done), 8'(want.done));
            check_field("read_data", got.rdata, want.rdata);
            check_field("ack_received", 8'(got.ack), 8'(want.ack));
            checked++;
        endtask

    endclass

endpackage

[tb/sv/tb_top.sv]
// Top of the I2C master bit sequencer bench: clock, reset, request driver and result monitor.
// Depends on i2cbs_pkg and on the scoreboard in i2cbs_tb_pkg.
module tb_top;

    import i2cbs_pkg::*;
    import i2cbs_tb_pkg::*;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int SDA_LOW     = 0;
    localparam int SDA_HIGH    = 1;
    localparam int SDA_RANDOM  = 2;
    localparam int PHASE_TICKS = 290;
    localparam int CYCLE_LIMIT = 300000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] kind;
    logic [7:0] write_data;
    logic       ack_to_send;
    logic       sda_in;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;

    i2c_tick_scoreboard sb = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int ticks_sent = 0;
    int cycles = 0;

    i2c_master_bit_sequencer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .write_data   (write_data),
        .ack_to_send  (ack_to_send),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_data    (read_data),
        .ack_received (ack_received)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_tick({scl_out, sda_out, busy_res, done_res, read_data, ack_received});
    end

    function logic pick_sda(int mode);
        if (mode == SDA_RANDOM)
            return 1'($urandom_range(0, 1));
        return (mode == SDA_HIGH);
    endfunction

    // Hold the request until accepted, with random idle gaps before it.
    task send_tick(logic [2:0] k, logic [7:0] wd, logic ack_bit, logic sda_bit);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        write_data  <= wd;
        ack_to_send <= ack_bit;
        sda_in      <= sda_bit;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_tick(k, wd, ack_bit, sda_bit);
        ticks_sent++;
    endtask

    // Issue one command, then tick until it ends; noise ticks carry commands the block drops.
    task run_command(cmd_t c, logic [7:0] wd, logic ack_bit, int sda_mode, int noise_pct);
        logic [2:0] k;
        send_tick(c, wd, ack_bit, pick_sda(sda_mode));
        while (sb.busy())
        begin
            if ($urandom_range(0, 99) < noise_pct)
                k = 3'($urandom_range(0, 7));
            else
                k = CMD_IDLE;
            send_tick(k, 8'($urandom), 1'($urandom), pick_sda(sda_mode));
        end
    endtask

    task run_transaction();
        int   n_bytes;
        logic reading;
        logic last;
        if ($urandom_range(0, 9) == 0)
        begin
            // Raw noise: any kind, any payload.
            repeat ($urandom_range(1, 6))
                send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
            return;
        end
        repeat ($urandom_range(0, 2))
            send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
        reading = 1'($urandom_range(0, 1));
        n_bytes = $urandom_range(1, 2);
        run_command(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 10);
        run_command(CMD_WRITE, {7'($urandom), reading}, 1'($urandom), SDA_RANDOM, 10);
        run_command(CMD_RACK, 8'($urandom), 1'($urandom), SDA_RANDOM, 10);
        for (int i = 0; i < n_bytes; i++)
        begin
            last = (i == n_bytes - 1);
            if (reading)
            begin
                run_command(CMD_READ, 8'($urandom), 1'($urandom), SDA_RANDOM, 10);
                run_command(CMD_SACK, 8'($urandom), last ^ ($urandom_range(0, 9) == 0),
                            SDA_RANDOM, 10);
            end
            else
            begin
                run_command(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 10);
                run_command(CMD_RACK, 8'($urandom), 1'($urandom), SDA_RANDOM, 10);
            end
        end
        // Drop the stop now and then to leave a broken transfer.
        if ($urandom_range(0, 19) != 0)
            run_command(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 10);
    endtask

    initial
    begin
        int target;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = CMD_IDLE;
        write_data  = 8'h00;
        ack_to_send = 1'b0;
        sda_in      = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_tick(CMD_IDLE, 8'h00, 1'b0, 1'b0);
        send_tick(KIND_UNUSED, 8'hFF, 1'b1, 1'b1);
        run_command(CMD_START, 8'h00, 1'b0, SDA_HIGH, 100);
        run_command(CMD_WRITE, 8'hFF, 1'b1, SDA_LOW, 100);
        run_command(CMD_RACK, 8'h00, 1'b0, SDA_LOW, 0);
        run_command(CMD_WRITE, 8'h00, 1'b0, SDA_HIGH, 0);
        run_command(CMD_RACK, 8'hFF, 1'b1, SDA_HIGH, 0);
        run_command(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 0);
        run_command(CMD_SACK, 8'h00, 1'b0, SDA_HIGH, 0);
        run_command(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 100);
        run_command(CMD_SACK, 8'h00, 1'b1, SDA_LOW, 0);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
        send_tick(CMD_IDLE, 8'hFF, 1'b1, 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 77; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            target = ticks_sent + PHASE_TICKS;
            while (ticks_sent < target)
                run_transaction();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("drove %0d bus ticks over four pacing phases; %0d commands ran to completion",
                 ticks_sent, sb.finished_cmds);
        $display("%0d results compared, with commands while busy and the unused kind mixed in",
                 sb.checked);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
